// File: src/mexp_pkg.sv
// Package for the modular exponentiation unit: widths, controller states
// and the command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int OPERAND_WIDTH  = 32;
    localparam int EXPONENT_WIDTH = 32;
    localparam int DATA_WIDTH     = 32;
    localparam int STEP_CNT_W     = $clog2(OPERAND_WIDTH);
    localparam int BIT_CNT_W      = $clog2(EXPONENT_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] t_operand;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_PICK = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;       // capture a new item, set up the base reduction
        logic setup;      // set up a modular product
        logic setup_acc;  // addend is the running result (else the base)
        logic step;       // one shift-add-reduce step
        logic wr_acc;     // write the finished product to the running result
        logic wr_base;    // write the finished product to the base
        logic clr_bit;    // clear the current exponent bit
        logic shift_exp;  // advance to the next exponent bit
        logic out_load;   // move the running result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last;       // current step is the final one of a product
        logic exp_bit;    // current exponent bit
        logic exp_done;   // every exponent bit scanned
    } t_dp_status;

endpackage

`default_nettype wire

// File: src/mexp_in_if.sv
// Input channel of the modular exponentiation unit: valid/ready plus the
// base and exponent. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if
    import mexp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] base_value;
    logic [DATA_WIDTH-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

`default_nettype wire

// File: src/mexp_out_if.sv
// Output channel of the modular exponentiation unit: valid/ready plus the
// result. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_out_if
    import mexp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

// File: src/mexp_ctrl.sv
// Controller of the modular exponentiation unit: sequences reduction,
// multiply and square steps and owns the output valid flag. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    o_cmd.wr_base = 1'b1;
                    n_state       = S_PICK;
                end
            end
            S_PICK: begin
                if (i_status.exp_done) begin
                    n_state = S_OUT;
                end else if (i_status.exp_bit) begin
                    o_cmd.setup     = 1'b1;
                    o_cmd.setup_acc = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_SQR;
                end
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    // drop the bit so the next pick goes on to the square
                    o_cmd.wr_acc  = 1'b1;
                    o_cmd.clr_bit = 1'b1;
                    n_state       = S_PICK;
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    o_cmd.wr_base   = 1'b1;
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_PICK;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: src/mexp_dp.sv
// Datapath of the modular exponentiation unit: modulus register, base,
// running result, exponent scan and a bit-serial modular multiplier. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp
    import mexp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [DATA_WIDTH-1:0] i_cfg_wdata,
    input  wire  [DATA_WIDTH-1:0] i_base_value,
    input  wire  [DATA_WIDTH-1:0] i_exponent,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [DATA_WIDTH-1:0] o_power_result
);

    localparam int SUM_W = OPERAND_WIDTH + 2;

    t_operand                  r_mod;
    t_operand                  r_base;
    t_operand                  r_acc;
    t_operand                  r_addend;
    t_operand                  r_mbits;
    t_operand                  r_part;
    logic [STEP_CNT_W-1:0]     r_step;
    logic [EXPONENT_WIDTH-1:0] r_exp;
    logic [BIT_CNT_W-1:0]      r_bits;
    logic [DATA_WIDTH-1:0]     r_result;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] mod_x1;
    logic [SUM_W-1:0] mod_x2;
    logic [SUM_W-1:0] red_sum;
    t_operand         n_part;
    t_operand         cfg_val;

    // Shift-add with interleaved reduction: the partial stays below the
    // modulus and the addend is at most the modulus, so the sum is below
    // three times the modulus and one subtract of m or 2m brings it back.
    always_comb begin
        sum    = {1'b0, r_part, 1'b0}
               + (r_mbits[OPERAND_WIDTH-1] ? {2'b00, r_addend} : '0);
        mod_x1 = {2'b00, r_mod};
        mod_x2 = {1'b0, r_mod, 1'b0};
        if (sum >= mod_x2) begin
            red_sum = sum - mod_x2;
        end else if (sum >= mod_x1) begin
            red_sum = sum - mod_x1;
        end else begin
            red_sum = sum;
        end
        n_part = red_sum[OPERAND_WIDTH-1:0];
    end

    assign cfg_val           = i_cfg_wdata[OPERAND_WIDTH-1:0];
    assign o_status.last     = (r_step == STEP_CNT_W'(OPERAND_WIDTH - 1));
    assign o_status.exp_bit  = r_exp[0];
    assign o_status.exp_done = (r_bits == BIT_CNT_W'(EXPONENT_WIDTH));
    assign o_power_result    = r_result;

    // modulus: a write of zero is ignored, so the register never holds 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= t_operand'(1);
        end else if (i_cfg_we && (cfg_val != '0)) begin
            r_mod <= cfg_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // reduce the base as the product 1 * base
            r_addend <= t_operand'(1);
            r_mbits  <= i_base_value[OPERAND_WIDTH-1:0];
            r_part   <= '0;
            r_step   <= '0;
            r_acc    <= t_operand'(1);
            r_exp    <= i_exponent[EXPONENT_WIDTH-1:0];
            r_bits   <= '0;
        end else begin
            if (i_cmd.setup) begin
                r_addend <= i_cmd.setup_acc ? r_acc : r_base;
                r_mbits  <= r_base;
                r_part   <= '0;
                r_step   <= '0;
            end
            if (i_cmd.step) begin
                r_part  <= n_part;
                r_mbits <= {r_mbits[OPERAND_WIDTH-2:0], 1'b0};
                r_step  <= r_step + STEP_CNT_W'(1);
            end
            if (i_cmd.wr_acc) begin
                r_acc <= n_part;
            end
            if (i_cmd.wr_base) begin
                r_base <= n_part;
            end
            if (i_cmd.clr_bit) begin
                r_exp[0] <= 1'b0;
            end
            if (i_cmd.shift_exp) begin
                r_exp  <= r_exp >> 1;
                r_bits <= r_bits + BIT_CNT_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_result <= DATA_WIDTH'(r_acc);
        end
    end

endmodule

`default_nettype wire

// File: src/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: joins controller and
// datapath to the channel interfaces. Depends on mexp_pkg, mexp_in_if, mexp_out_if.
`timescale 1ns / 1ps
`default_nettype none

// Computes base_value ^ exponent mod modulus by right-to-left binary
// square-and-multiply. The user is to write the modulus through
// i_cfg_we/i_cfg_wdata only while the unit is idle, which the unit does not
// enforce; it resets to 1 and a write of zero is ignored.
// An item is a transfer on i_in; its result is one transfer on o_out. A zero
// exponent always gives 1. One item is worked at a time: every modular
// product runs through a single bit-serial shift-add-reduce unit at one
// operand bit per cycle. After the input transfer an item reduces the base,
// then for each of the 32 exponent bits does the multiply when the bit is 1
// and then the square, with a decision step before each product, then makes
// a decision that ends the scan and loads the output register once it is
// free. The output register lets the next item be taken while a result waits.
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [DATA_WIDTH-1:0] i_cfg_wdata,
    mexp_in_if.sink              i_in,
    mexp_out_if.source           o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequence the steps; hold the result until the sink takes it
    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // modulus, operands and the serial multiplier
    mexp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_base_value   (i_in.base_value),
        .i_exponent     (i_in.exponent),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_power_result (o_out.power_result)
    );

endmodule

`default_nettype wire

// File: src/mexp_checker.sv
// Port-level checker for the modular exponentiation unit, bound to the
// top level. Depends on mexp_pkg and modular_exponentiation_unit.
`timescale 1ns / 1ps
`default_nettype none

module mexp_port_checker
    import mexp_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_ready,
    input wire                  i_out_valid,
    input wire                  i_out_ready,
    input wire [DATA_WIDTH-1:0] i_power_result
);

    // a result waiting for the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_power_result))
        else $error("stalled result changed");

    // one item at a time: no second transfer straight after an input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // no result can appear the cycle after an item is taken
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind modular_exponentiation_unit mexp_port_checker u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_power_result (o_out.power_result)
);

`default_nettype wire
